/* hw/rtl/afgr_pkg.sv */
// ----------------------------------------------------------------------------
// afgr_pkg: shared types, constants and font table
// Result kinds, controller states, command/status structs and the 3x5 glyph
// table of the ASCII frame glyph rasteriser.
// ----------------------------------------------------------------------------
`default_nettype none

package afgr_pkg;

  // Default width of the frame count accumulator
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Screen and cell geometry
  localparam int unsigned SCREEN_W  = 240;
  localparam int unsigned SCREEN_H  = 160;
  localparam int unsigned CELL_W    = 4;
  localparam int unsigned CELL_H    = 6;
  localparam int unsigned CELL_COLS = SCREEN_W / CELL_W;
  localparam int unsigned GLYPH_W   = 3;
  localparam int unsigned GLYPH_H   = 5;
  localparam int unsigned GLYPH_BITS = GLYPH_W * GLYPH_H;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ROWS_W  = 5;
  localparam int unsigned SKIP_W  = 6;
  localparam int unsigned MARG_W  = 8;
  localparam int unsigned COORD_W = 8;
  localparam int unsigned HOLD_W  = 16;
  localparam int unsigned CFG_W   = 8;

  // Character codes
  localparam logic [BYTE_W-1:0] CHAR_NUL  = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_NL   = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_ZERO = "0";
  localparam logic [BYTE_W-1:0] CHAR_NINE = "9";
  localparam logic [BYTE_W-1:0] COL_MAX   = 8'hFF;

  // Register reset values
  localparam logic [ROWS_W-1:0] ROWS_RST = 5'd13;
  localparam logic [SKIP_W-1:0] SKIP_RST = 6'd3;
  localparam logic [MARG_W-1:0] MARG_RST = 8'd38;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ROWS_PER_FRAME = 2'd0;
  localparam cfg_idx_t CFG_COLUMN_SKIP    = 2'd1;
  localparam cfg_idx_t CFG_TOP_MARGIN     = 2'd2;

  typedef enum logic [1:0] {
    KIND_PLOT  = 2'd0,
    KIND_START = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_START_DONE,
    ST_DONE,
    ST_PLOT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic  step;   // decode the byte on the input and update the cursor
    logic  load;   // load the output register
    kind_e kind;
    logic  last;   // last word of the byte (kinds start and done)
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic ev_start;
    logic ev_start_done;
    logic ev_done;
    logic ev_plot;
    logic plot_pend;
    logic plot_last;
  } sts_t;

  // 3x5 font: five 3-bit rows, top row in the upper bits, left pixel is the MSB
  function automatic logic [GLYPH_BITS-1:0] glyph_of(input logic [BYTE_W-1:0] ch);
    logic [GLYPH_BITS-1:0] g;
    case (ch)
      ".":           g = {3'd0, 3'd0, 3'd0, 3'd0, 3'd1};
      "@":           g = {3'd7, 3'd1, 3'd3, 3'd5, 3'd7};
      "-":           g = {3'd0, 3'd0, 3'd6, 3'd0, 3'd0};
      "*", "+":      g = {3'd0, 3'd2, 3'd7, 3'd2, 3'd0};
      "=":           g = {3'd0, 3'd7, 3'd0, 3'd7, 3'd0};
      "|":           g = {3'd2, 3'd2, 3'd2, 3'd2, 3'd0};
      "#", "8":      g = {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
      "_":           g = {3'd0, 3'd0, 3'd0, 3'd0, 3'd7};
      "<":           g = {3'd1, 3'd2, 3'd4, 3'd2, 3'd1};
      ">":           g = {3'd4, 3'd2, 3'd1, 3'd2, 3'd4};
      "/":           g = {3'd1, 3'd1, 3'd2, 3'd2, 3'd4};
      "\\":          g = {3'd4, 3'd4, 3'd2, 3'd2, 3'd1};
      "(":           g = {3'd2, 3'd4, 3'd4, 3'd4, 3'd2};
      ")":           g = {3'd4, 3'd2, 3'd2, 3'd2, 3'd4};
      "[":           g = {3'd6, 3'd4, 3'd4, 3'd4, 3'd6};
      "]":           g = {3'd6, 3'd2, 3'd2, 3'd2, 3'd6};
      "o", "O", "0": g = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
      "a", "A":      g = {3'd2, 3'd5, 3'd7, 3'd5, 3'd5};
      "b", "B":      g = {3'd6, 3'd5, 3'd6, 3'd5, 3'd6};
      "c", "C":      g = {3'd3, 3'd4, 3'd4, 3'd4, 3'd3};
      "d", "D":      g = {3'd6, 3'd5, 3'd5, 3'd5, 3'd6};
      "e", "E":      g = {3'd7, 3'd4, 3'd7, 3'd4, 3'd7};
      "f", "F":      g = {3'd7, 3'd4, 3'd7, 3'd4, 3'd4};
      "g", "G":      g = {3'd7, 3'd4, 3'd5, 3'd5, 3'd7};
      "h", "H":      g = {3'd5, 3'd5, 3'd7, 3'd5, 3'd5};
      "i", "I":      g = {3'd7, 3'd2, 3'd2, 3'd2, 3'd7};
      "j", "J":      g = {3'd1, 3'd1, 3'd1, 3'd1, 3'd6};
      "k", "K":      g = {3'd5, 3'd5, 3'd6, 3'd5, 3'd5};
      "l", "L":      g = {3'd4, 3'd4, 3'd4, 3'd4, 3'd7};
      "m", "M":      g = {3'd5, 3'd7, 3'd5, 3'd5, 3'd5};
      "n", "N":      g = {3'd7, 3'd5, 3'd5, 3'd5, 3'd5};
      "p", "P":      g = {3'd7, 3'd5, 3'd7, 3'd4, 3'd4};
      "q", "Q":      g = {3'd2, 3'd5, 3'd5, 3'd5, 3'd3};
      "r", "R":      g = {3'd7, 3'd5, 3'd6, 3'd5, 3'd5};
      "s", "S":      g = {3'd3, 3'd4, 3'd2, 3'd1, 3'd6};
      "t", "T":      g = {3'd7, 3'd2, 3'd2, 3'd2, 3'd2};
      "u", "U":      g = {3'd5, 3'd5, 3'd5, 3'd5, 3'd7};
      "v", "V":      g = {3'd5, 3'd5, 3'd5, 3'd5, 3'd2};
      "w", "W":      g = {3'd5, 3'd5, 3'd5, 3'd7, 3'd5};
      "x", "X":      g = {3'd5, 3'd5, 3'd2, 3'd5, 3'd5};
      "y", "Y":      g = {3'd5, 3'd5, 3'd2, 3'd2, 3'd2};
      "z", "Z":      g = {3'd7, 3'd1, 3'd2, 3'd4, 3'd7};
      "~":           g = {3'd0, 3'd3, 3'd6, 3'd0, 3'd0};
      "1":           g = {3'd2, 3'd6, 3'd2, 3'd2, 3'd7};
      "2":           g = {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
      "3":           g = {3'd7, 3'd1, 3'd3, 3'd1, 3'd7};
      "4":           g = {3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
      "!":           g = {3'd2, 3'd2, 3'd2, 3'd0, 3'd2};
      "5":           g = {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
      "6":           g = {3'd4, 3'd4, 3'd7, 3'd5, 3'd7};
      "7":           g = {3'd7, 3'd1, 3'd1, 3'd1, 3'd1};
      "9":           g = {3'd7, 3'd5, 3'd7, 3'd1, 3'd1};
      "'":           g = {3'd2, 3'd2, 3'd0, 3'd0, 3'd0};
      "?":           g = {3'd7, 3'd1, 3'd3, 3'd0, 3'd2};
      "\"":          g = {3'd5, 3'd5, 3'd0, 3'd0, 3'd0};
      default:       g = '0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/afgr_in_if.sv */
// ----------------------------------------------------------------------------
// afgr_in_if: byte stream channel
// Valid/ready channel carrying one stream byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface afgr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

`default_nettype wire

/* hw/rtl/afgr_out_if.sv */
// ----------------------------------------------------------------------------
// afgr_out_if: result channel
// Valid/ready channel carrying one plot, frame start or frame done per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface afgr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  pixel_x;
  logic [7:0]  pixel_y;
  logic [15:0] frame_hold_count;
  logic        last_of_run;

  modport source (output valid, output result_kind, output pixel_x, output pixel_y,
                  output frame_hold_count, output last_of_run, input ready);
  modport sink (input valid, input result_kind, input pixel_x, input pixel_y,
                input frame_hold_count, input last_of_run, output ready);
endinterface

`default_nettype wire

/* hw/rtl/afgr_ctrl.sv */
// ----------------------------------------------------------------------------
// afgr_ctrl: sequencing state machine
// Takes a byte when idle, then issues the frame start, frame done and pixel
// words that the datapath reports for it.
// ----------------------------------------------------------------------------
`default_nettype none

module afgr_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  afgr_pkg::sts_t     sts_i,
  output afgr_pkg::cmd_t     cmd_o
);
  import afgr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o.step  = 1'b0;
    cmd_o.load  = 1'b0;
    cmd_o.kind  = KIND_PLOT;
    cmd_o.last  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.step = 1'b1;
          priority if (sts_i.ev_start_done) state_d = ST_START_DONE;
          else if (sts_i.ev_start)          state_d = ST_START;
          else if (sts_i.ev_done)           state_d = ST_DONE;
          else if (sts_i.ev_plot)           state_d = ST_PLOT;
          else                              state_d = ST_IDLE;
        end
      end
      ST_START: begin
        cmd_o.kind = KIND_START;
        cmd_o.last = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_START_DONE: begin
        cmd_o.kind = KIND_START;
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd_o.kind = KIND_DONE;
        cmd_o.last = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_PLOT: begin
        cmd_o.kind = KIND_PLOT;
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          if (sts_i.plot_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTH
  // pixel scan never runs on an empty mask
  a_plot_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PLOT |-> sts_i.plot_pend)
    else $error("plot state with empty glyph mask");

  // output register is only loaded when it can take a word
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> sts_i.out_free)
    else $error("output loaded while occupied");

  // the last pixel of a glyph returns to idle
  a_plot_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PLOT && cmd_o.load && sts_i.plot_last) |=> state_q == ST_IDLE)
    else $error("glyph scan did not finish");
`endif

endmodule

`default_nettype wire

/* hw/rtl/afgr_datapath.sv */
// ----------------------------------------------------------------------------
// afgr_datapath: cursor, count and glyph datapath
// Holds configuration, header/cursor state, the visible glyph mask of the
// current cell and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module afgr_datapath #(
  parameter int unsigned COUNT_BITS = afgr_pkg::COUNT_BITS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  afgr_pkg::cfg_idx_t         cfg_idx_i,
  input  wire  [afgr_pkg::CFG_W-1:0]       cfg_data_i,
  input  wire  [afgr_pkg::BYTE_W-1:0]      byte_i,
  input  afgr_pkg::cmd_t                   cmd_i,
  output afgr_pkg::sts_t                   sts_o,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [1:0]                       kind_o,
  output logic [afgr_pkg::COORD_W-1:0]     x_o,
  output logic [afgr_pkg::COORD_W-1:0]     y_o,
  output logic [afgr_pkg::HOLD_W-1:0]      cnt_o,
  output logic                             last_o
);
  import afgr_pkg::*;

  localparam int unsigned ACC_W = COUNT_BITS + 4;
  localparam int unsigned SY_W  = 10;

  // configuration
  logic [ROWS_W-1:0] rows_q;
  logic [SKIP_W-1:0] skip_q;
  logic [MARG_W-1:0] marg_q;

  // stream state
  logic                  header_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [ROWS_W-1:0]     row_q;
  logic [BYTE_W-1:0]     col_q;
  logic [HOLD_W-1:0]     hold_q;

  // current cell
  logic [GLYPH_BITS-1:0] mask_q, mask_d;
  logic [COORD_W-1:0]    sx_q, sx_d;
  logic [COORD_W-1:0]    sy_q;

  // output register
  logic               valid_q;
  kind_e              kind_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic [HOLD_W-1:0]  cnt_q;
  logic               last_q;

  logic is_digit, is_nl, is_nul;
  logic [ACC_W-1:0] acc_ext, acc_sum;
  logic [COUNT_BITS-1:0] count_sat;
  logic [COUNT_BITS+HOLD_W-1:0] count_wide;
  logic [ROWS_W-1:0] row_inc;
  logic [BYTE_W-1:0] col_rel;
  logic col_vis;
  logic [SY_W-1:0] sy_full;
  logic [GLYPH_BITS-1:0] glyph;
  logic out_free;
  logic [GLYPH_BITS-1:0] sel_oh;
  logic [2:0] sel_dy;
  logic [1:0] sel_dx;

  // ---- byte decode ----
  always_comb begin
    is_digit = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE);
    is_nl    = (byte_i == CHAR_NL);
    is_nul   = (byte_i == CHAR_NUL);

    // count * 10 + digit, saturating
    acc_ext = ACC_W'(count_q);
    acc_sum = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(byte_i - CHAR_ZERO);
    if (|acc_sum[ACC_W-1:COUNT_BITS]) count_sat = '1;
    else                              count_sat = acc_sum[COUNT_BITS-1:0];
    count_wide = {{HOLD_W{1'b0}}, count_q};

    row_inc = row_q + ROWS_W'(1);
    col_rel = col_q - BYTE_W'(skip_q);
    col_vis = (col_q >= BYTE_W'(skip_q)) && (col_rel < BYTE_W'(CELL_COLS));
    sx_d    = {col_rel[COORD_W-3:0], 2'b00};
    sy_full = (SY_W'(row_q) << 2) + (SY_W'(row_q) << 1) + SY_W'(marg_q);

    glyph  = glyph_of(byte_i);
    mask_d = '0;
    for (int dy = 0; dy < GLYPH_H; dy++) begin
      if ((sy_full + SY_W'(dy)) < SY_W'(SCREEN_H)) begin
        mask_d[GLYPH_BITS-1-GLYPH_W*dy -: GLYPH_W] =
          glyph[GLYPH_BITS-1-GLYPH_W*dy -: GLYPH_W];
      end
    end
    if (!col_vis) mask_d = '0;
  end

  // ---- pixel pick: highest mask bit first (raster order) ----
  always_comb begin
    sel_oh = '0;
    sel_dy = '0;
    sel_dx = '0;
    for (int i = 0; i < GLYPH_BITS; i++) begin
      if (mask_q[i]) begin
        sel_oh = GLYPH_BITS'(1) << i;
        sel_dy = 3'((GLYPH_BITS - 1 - i) / GLYPH_W);
        sel_dx = 2'((GLYPH_BITS - 1 - i) % GLYPH_W);
      end
    end
  end

  assign out_free = !valid_q || out_ready_i;

  always_comb begin
    sts_o.out_free      = out_free;
    sts_o.ev_start      = header_q && is_nl;
    sts_o.ev_start_done = header_q && is_nl && (rows_q == '0);
    sts_o.ev_done       = !header_q && (is_nul || (is_nl && (row_inc >= rows_q)));
    sts_o.ev_plot       = !header_q && !is_nul && !is_nl && (|mask_d);
    sts_o.plot_pend     = |mask_q;
    sts_o.plot_last     = ~|(mask_q & ~sel_oh);
  end

  // ---- configuration ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RST;
      skip_q <= SKIP_RST;
      marg_q <= MARG_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROWS_PER_FRAME: rows_q <= cfg_data_i[ROWS_W-1:0];
        CFG_COLUMN_SKIP:    skip_q <= cfg_data_i[SKIP_W-1:0];
        CFG_TOP_MARGIN:     marg_q <= cfg_data_i[MARG_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- stream state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= 1'b1;
      count_q  <= '0;
      row_q    <= '0;
      col_q    <= '0;
      mask_q   <= '0;
    end else if (cmd_i.step) begin
      if (header_q) begin
        if (is_digit) begin
          count_q <= count_sat;
        end else if (is_nl) begin
          count_q  <= '0;
          row_q    <= '0;
          col_q    <= '0;
          header_q <= (rows_q == '0);
        end
      end else if (is_nul) begin
        header_q <= 1'b1;
      end else if (is_nl) begin
        row_q <= row_inc;
        col_q <= '0;
        if (row_inc >= rows_q) header_q <= 1'b1;
      end else begin
        if (col_q != COL_MAX) col_q <= col_q + BYTE_W'(1);
        mask_q <= mask_d;
      end
    end else if (cmd_i.load && cmd_i.kind == KIND_PLOT) begin
      mask_q <= mask_q & ~sel_oh;
    end
  end

  // cell origin and frame count snapshot
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      sx_q   <= sx_d;
      sy_q   <= sy_full[COORD_W-1:0];
      hold_q <= count_wide[HOLD_W-1:0];
    end
  end

  // ---- output register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= cmd_i.kind;
      if (cmd_i.kind == KIND_PLOT) begin
        x_q    <= sx_q + COORD_W'(sel_dx);
        y_q    <= sy_q + COORD_W'(sel_dy);
        last_q <= sts_o.plot_last;
      end else begin
        x_q    <= '0;
        y_q    <= '0;
        last_q <= cmd_i.last;
      end
      cnt_q <= (cmd_i.kind == KIND_START) ? hold_q : '0;
    end
  end

  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign x_o         = x_q;
  assign y_o         = y_q;
  assign cnt_o       = cnt_q;
  assign last_o      = last_q;

`ifndef SYNTH
  // plotted pixels stay on screen
  a_plot_onscreen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q == KIND_PLOT) |-> (x_q < COORD_W'(SCREEN_W) && y_q < COORD_W'(SCREEN_H)))
    else $error("pixel off screen");

  // frame start and done carry no coordinates
  a_event_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q != KIND_PLOT) |-> (x_q == '0 && y_q == '0))
    else $error("event word with coordinates");
`endif

endmodule

`default_nettype wire

/* hw/rtl/ascii_frame_glyph_rasterizer_top.sv */
// ----------------------------------------------------------------------------
// ascii_frame_glyph_rasterizer_top: ASCII animation text rasteriser
// Parses a header frame count, then draws each frame byte as a 3x5 glyph in a
// 4x6 cell and emits one word per lit pixel, plus frame start and done words.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | word
//  ---------+-----+----------------------+-----------------------------------
//  in_i     | in  | valid/ready          | stream_byte
//  out_o    | out | valid/ready          | kind, x, y, hold count, last flag
//  cfg      | in  | cfg_we_i, no stall   | cfg_idx_i, cfg_data_i
//
//  A byte is taken when the controller is idle, and is decoded and the cursor
//  moves as it is taken; it then occupies the controller while its result words
//  (0..13 of them) are issued through the single output register, which takes
//  one word a cycle unless the sink stalls it.
//  A stalled output register holds the word and the controller waits on it;
//  no new byte is taken until the last word of the current one is loaded.
//  Reset (rst_ni, asynchronous, active low) restores header mode, clears the
//  count and cursor, and loads the register defaults 13 / 3 / 38.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_frame_glyph_rasterizer_top #(
  parameter int unsigned COUNT_BITS = afgr_pkg::COUNT_BITS_DEF
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  afgr_in_if.sink                    in_i,
  afgr_out_if.source                 out_o,
  input  wire                        cfg_we_i,
  input  wire  afgr_pkg::cfg_idx_t   cfg_idx_i,
  input  wire  [afgr_pkg::CFG_W-1:0] cfg_data_i
);
  import afgr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller: byte acceptance and word sequencing
  afgr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: count parse, cursor, glyph mask, output register
  afgr_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .byte_i      (in_i.stream_byte),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .kind_o      (out_o.result_kind),
    .x_o         (out_o.pixel_x),
    .y_o         (out_o.pixel_y),
    .cnt_o       (out_o.frame_hold_count),
    .last_o      (out_o.last_of_run)
  );

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ASCII frame glyph rasteriser
// Drives header and frame bytes into the block, predicts every plot, frame
// start and frame done word, and checks each output word in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  // --------------------------------------------------------------------------
  // Bench constants
  // --------------------------------------------------------------------------
  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 3;
  // Wait after the last owed word, so a trailing byte can work its way through.
  localparam int SETTLE_CYCLES   = 16;
  // Upper bound on the whole run before the watchdog fires.
  localparam int WATCHDOG_CYCLES = 2_000_000;
  localparam int RANDOM_BYTES    = 420;
  localparam int MAX_REPORTS     = 10;
  localparam int HOLD_OFF_CYCLES = 400;

  // Screen geometry, as the font grid defines it
  localparam int SCR_W_PX   = 240;
  localparam int SCR_H_PX   = 160;
  localparam int CELL_W_PX  = 4;
  localparam int CELL_H_PX  = 6;
  localparam int TEXT_COLS  = SCR_W_PX / CELL_W_PX;
  localparam longint unsigned COUNT_MAX = 64'd65535;

  localparam logic [7:0] NL      = afgr_pkg::CHAR_NL;
  localparam logic [7:0] NUL     = afgr_pkg::CHAR_NUL;
  localparam logic [7:0] COL_SAT = 8'hFF;

  localparam afgr_pkg::cfg_idx_t REG_ROWS   = afgr_pkg::CFG_ROWS_PER_FRAME;
  localparam afgr_pkg::cfg_idx_t REG_SKIP   = afgr_pkg::CFG_COLUMN_SKIP;
  localparam afgr_pkg::cfg_idx_t REG_MARGIN = afgr_pkg::CFG_TOP_MARGIN;

  // One output word as it should appear on the result channel
  typedef struct packed {
    afgr_pkg::kind_e kind;
    logic [7:0]      px;
    logic [7:0]      py;
    logic [15:0]     hold;
    logic            last;
  } raster_word_t;

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block itself
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  logic                      cfg_we;
  afgr_pkg::cfg_idx_t        cfg_idx;
  logic [afgr_pkg::CFG_W-1:0] cfg_data;

  afgr_in_if  in_if ();
  afgr_out_if out_if ();

  always #(CLK_PERIOD / 2) clk = ~clk;

  ascii_frame_glyph_rasterizer_top DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predictor state: our own copy of the block's mode, cursor and registers
  // --------------------------------------------------------------------------
  bit               hdr_mode;
  longint unsigned  acc_count;
  logic [4:0]       text_row;
  logic [7:0]       text_col;
  logic [4:0]       cfg_rows;
  logic [5:0]       cfg_skip;
  logic [7:0]       cfg_margin;

  raster_word_t     due_words[$];       // words still owed by the block, oldest first
  raster_word_t     this_byte_words[$]; // scratch: words caused by one byte

  // Run bookkeeping
  int  bytes_sent;
  int  mismatches;
  int  plots_seen;
  int  starts_seen;
  int  dones_seen;
  bit  sender_idles;
  bit  sink_idles;
  int  sink_hold_cycles;
  bit  long_line_done;

  // --------------------------------------------------------------------------
  // 3x5 font, one octal digit per glyph row (top row first, 4 = left pixel)
  // --------------------------------------------------------------------------
  function automatic logic [14:0] font_bits(input logic [7:0] ch);
    case (ch)
      ".":           return 15'o00001;
      "@":           return 15'o71357;
      "-":           return 15'o00600;
      "*", "+":      return 15'o02720;
      "=":           return 15'o07070;
      "|":           return 15'o22220;
      "#", "8":      return 15'o75757;
      "_":           return 15'o00007;
      "<":           return 15'o12421;
      ">":           return 15'o42124;
      "/":           return 15'o11224;
      "\\":          return 15'o44221;
      "(":           return 15'o24442;
      ")":           return 15'o42224;
      "[":           return 15'o64446;
      "]":           return 15'o62226;
      "o", "O", "0": return 15'o75557;
      "a", "A":      return 15'o25755;
      "b", "B":      return 15'o65656;
      "c", "C":      return 15'o34443;
      "d", "D":      return 15'o65556;
      "e", "E":      return 15'o74747;
      "f", "F":      return 15'o74744;
      "g", "G":      return 15'o74557;
      "h", "H":      return 15'o55755;
      "i", "I":      return 15'o72227;
      "j", "J":      return 15'o11116;
      "k", "K":      return 15'o55655;
      "l", "L":      return 15'o44447;
      "m", "M":      return 15'o57555;
      "n", "N":      return 15'o75555;
      "p", "P":      return 15'o75744;
      "q", "Q":      return 15'o25553;
      "r", "R":      return 15'o75655;
      "s", "S":      return 15'o34216;
      "t", "T":      return 15'o72222;
      "u", "U":      return 15'o55557;
      "v", "V":      return 15'o55552;
      "w", "W":      return 15'o55575;
      "x", "X":      return 15'o55255;
      "y", "Y":      return 15'o55222;
      "z", "Z":      return 15'o71247;
      "~":           return 15'o03600;
      "1":           return 15'o26227;
      "2":           return 15'o71747;
      "3":           return 15'o71317;
      "4":           return 15'o55711;
      "!":           return 15'o22202;
      "5":           return 15'o74717;
      "6":           return 15'o44757;
      "7":           return 15'o71111;
      "9":           return 15'o75711;
      "'":           return 15'o22000;
      "?":           return 15'o71302;
      "\"":          return 15'o55000;
      default:       return 15'o00000;
    endcase
  endfunction

  function automatic void stage_word(input afgr_pkg::kind_e k, input int x, input int y,
                                     input longint unsigned cnt);
    raster_word_t w;
    w.kind = k;
    w.px   = x[7:0];
    w.py   = y[7:0];
    w.hold = cnt[15:0];
    w.last = 1'b0;
    this_byte_words.push_back(w);
  endfunction

  // Advance the predictor by one accepted byte and queue the words it causes.
  function automatic void raster_byte(input logic [7:0] b);
    int          col;
    int          sx;
    int          sy;
    logic [14:0] g;
    raster_word_t w;
    this_byte_words.delete();
    if (hdr_mode) begin
      if (b >= "0" && b <= "9") begin
        acc_count = acc_count * 10 + (b - "0");
        if (acc_count > COUNT_MAX) acc_count = COUNT_MAX;
      end else if (b == NL) begin
        stage_word(afgr_pkg::KIND_START, 0, 0, acc_count);
        acc_count = 0;
        text_row  = '0;
        text_col  = '0;
        // a zero row count closes the frame on the spot
        if (cfg_rows == 0) stage_word(afgr_pkg::KIND_DONE, 0, 0, 0);
        else hdr_mode = 1'b0;
      end
      // anything else in the header is ignored
    end else if (b == NUL) begin
      stage_word(afgr_pkg::KIND_DONE, 0, 0, 0);
      hdr_mode = 1'b1;
    end else if (b == NL) begin
      text_row = text_row + 5'd1;
      text_col = '0;
      if (text_row >= cfg_rows) begin
        stage_word(afgr_pkg::KIND_DONE, 0, 0, 0);
        hdr_mode = 1'b1;
      end
    end else begin
      col = text_col;
      if (text_col != COL_SAT) text_col = text_col + 8'd1;
      if (col >= cfg_skip && col - cfg_skip < TEXT_COLS) begin
        sx = (col - cfg_skip) * CELL_W_PX;
        sy = text_row * CELL_H_PX + cfg_margin;
        g  = font_bits(b);
        for (int dy = 0; dy < 5; dy++) begin
          for (int dx = 0; dx < 3; dx++) begin
            if (g[14 - (dy * 3 + dx)] && sy + dy < SCR_H_PX)
              stage_word(afgr_pkg::KIND_PLOT, sx + dx, sy + dy, 0);
          end
        end
      end
    end
    foreach (this_byte_words[i]) begin
      w      = this_byte_words[i];
      w.last = (i == this_byte_words.size() - 1);
      due_words.push_back(w);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Idle gaps: mostly none or short, now and then a long one
  // --------------------------------------------------------------------------
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Byte sender: offers one byte, predicts on acceptance. Valid is only
  // lowered ahead of a gap, so back-to-back bytes never see a 0-then-1 pair
  // of updates in one step.
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = sender_idles ? idle_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.stream_byte <= b;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    raster_byte(b);
    bytes_sent++;
  endtask

  // Stop offering, wait for every owed word, then let a trailing byte that
  // owes nothing work its way through.
  task automatic settle_after_results();
    in_if.valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write, only ever with the block idle
  task automatic write_reg(input afgr_pkg::cfg_idx_t idx, input logic [7:0] value);
    settle_after_results();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ROWS:   cfg_rows   = value[4:0];
      REG_SKIP:   cfg_skip   = value[5:0];
      REG_MARGIN: cfg_margin = value[7:0];
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Result sink: random stalls, plus a long hold-off on request, counted here
  // --------------------------------------------------------------------------
  initial begin
    int hold;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_cycles > 0) begin
        hold             = sink_hold_cycles;
        sink_hold_cycles = 0;
        out_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
        out_if.ready <= 1'b1;
      end else if (sink_idles && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat (idle_gap() + 1) @(posedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: each accepted word against the oldest owed word
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    raster_word_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (due_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected word: kind %0d x %0d y %0d count %0d last %0b",
                   out_if.result_kind, out_if.pixel_x, out_if.pixel_y,
                   out_if.frame_hold_count, out_if.last_of_run);
      end else begin
        want = due_words.pop_front();
        case (want.kind)
          afgr_pkg::KIND_PLOT:  plots_seen++;
          afgr_pkg::KIND_START: starts_seen++;
          default:              dones_seen++;
        endcase
        if (out_if.result_kind !== want.kind || out_if.pixel_x !== want.px ||
            out_if.pixel_y !== want.py || out_if.frame_hold_count !== want.hold ||
            out_if.last_of_run !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("word mismatch: expected kind %0d x %0d y %0d count %0d last %0b, %s",
                     want.kind, want.px, want.py, want.hold, want.last,
                     $sformatf("got kind %0d x %0d y %0d count %0d last %0b",
                               out_if.result_kind, out_if.pixel_x, out_if.pixel_y,
                               out_if.frame_hold_count, out_if.last_of_run));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Header with junk bytes (a NUL among them) and a count that overflows
  // and must saturate. Register defaults still apply.
  task automatic test_header_parsing();
    push_byte("x");
    push_byte(NUL);
    push_byte("7");
    repeat (4) push_byte("0");
    push_byte(NL);
  endtask

  // Left clip through the default column skip, glyph cells, a byte with no
  // glyph, a row change, NUL closing the frame, and the count cleared after
  // a frame start.
  task automatic test_glyph_cells();
    push_byte("A");
    push_byte("B");
    push_byte("C");
    push_byte("@");
    push_byte(8'hFF);
    push_byte("#");
    push_byte(NL);
    push_byte("8");
    push_byte(NUL);
    push_byte(NL);
    push_byte(NUL);
  endtask

  // Zero rows: start and done come out of one header newline.
  task automatic test_zero_rows();
    write_reg(REG_ROWS, 8'd0);
    push_byte("5");
    push_byte(NL);
  endtask

  // Row limit dropped below the current row while a frame is open.
  task automatic test_row_limit_lowered();
    write_reg(REG_ROWS, 8'd5);
    push_byte(NL);
    push_byte(NL);
    push_byte(NL);
    write_reg(REG_ROWS, 8'd1);
    push_byte(NL);
  endtask

  // Bottom clip: a glyph straddling the last screen row, then a fully
  // clipped row.
  task automatic test_bottom_clip();
    write_reg(REG_SKIP, 8'd0);
    write_reg(REG_MARGIN, 8'd157);
    write_reg(REG_ROWS, 8'd2);
    push_byte(NL);
    push_byte("#");
    push_byte(NL);
    push_byte("#");
    push_byte(NL);
  endtask

  // Long hold-off on the result side while bytes keep coming: the output
  // register fills and the input must stall. Then the sender waits for
  // everything owed before going on.
  task automatic test_backpressure();
    write_reg(REG_ROWS, 8'd26);
    write_reg(REG_MARGIN, 8'd0);
    sender_idles = 1'b0;
    sink_idles   = 1'b0;
    push_byte("1");
    push_byte(NL);
    sink_hold_cycles = HOLD_OFF_CYCLES;
    for (int i = 0; i < 20; i++) begin
      case (i % 3)
        0:       push_byte("#");
        1:       push_byte("@");
        default: push_byte("8");
      endcase
    end
    push_byte(NUL);
    settle_after_results();
    sender_idles = 1'b1;
    sink_idles   = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Random stimulus
  // --------------------------------------------------------------------------
  function automatic logic [7:0] header_noise();
    logic [7:0] c;
    do c = $urandom_range(0, 255);
    while ((c >= "0" && c <= "9") || c == NL);
    return c;
  endfunction

  // Mostly printable (nearly all have glyphs), sometimes any byte but
  // newline and NUL.
  function automatic logic [7:0] frame_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) return $urandom_range(33, 126);
    do c = $urandom_range(1, 255);
    while (c == NL);
    return c;
  endfunction

  function automatic int line_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 8);
    if (r < 9) return $urandom_range(9, 20);
    return $urandom_range(40, 75);   // runs off the right edge for small skips
  endfunction

  // New register settings, extremes included; each register written or not.
  task automatic random_config();
    int r;
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 9);
      write_reg(REG_ROWS, r == 0 ? 8'd0 : r == 1 ? 8'd26 : r == 2 ? 8'd31 :
                          r == 3 ? 8'd1 : 8'($urandom_range(1, 4)));
    end
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 9);
      write_reg(REG_SKIP, r == 0 ? 8'd0 : r == 1 ? 8'd59 : r == 2 ? 8'd63 :
                          8'($urandom_range(0, 6)));
    end
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 9);
      write_reg(REG_MARGIN, r == 0 ? 8'd0 : r == 1 ? 8'd159 : r == 2 ? 8'd255 :
                            r == 3 ? 8'($urandom_range(150, 158)) :
                            8'($urandom_range(0, 120)));
    end
  endtask

  // Mostly a clean count and newline; sometimes junk only, sometimes a long
  // digit run that can saturate.
  task automatic random_header();
    int ndig;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) push_byte(header_noise());
    end else begin
      ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 3);
      for (int i = 0; i < ndig; i++) begin
        if ($urandom_range(0, 6) == 0) push_byte(header_noise());
        push_byte(8'("0" + $urandom_range(0, 9)));
      end
      push_byte(NL);
    end
  endtask

  // Text lines until the frame closes; now and then a frame is cut short by
  // NUL or left open so the next settings land mid-frame.
  task automatic random_lines(input int first_byte);
    int lines;
    int len;
    lines = 0;
    while (!hdr_mode && lines < 32) begin
      if (lines > 0 && $urandom_range(0, 9) == 0) break;
      len = line_length();
      // one very long line shows the column saturates rather than wrapping
      if (!long_line_done && bytes_sent - first_byte > 150) begin
        len            = $urandom_range(258, 290);
        long_line_done = 1'b1;
      end
      for (int i = 0; i < len; i++) push_byte(frame_char());
      if ($urandom_range(0, 19) == 0) push_byte(NUL);
      else push_byte(NL);
      lines++;
    end
  endtask

  task automatic test_random_stream();
    int  first_byte;
    bit  quiet;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) < 4) random_config();
      // some phases run with no idling on either side
      quiet        = ($urandom_range(0, 4) == 0);
      sender_idles = !quiet;
      sink_idles   = !quiet;
      if (hdr_mode) random_header();
      else random_lines(first_byte);
    end
  endtask

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin
    #(WATCHDOG_CYCLES * CLK_PERIOD);
    $display("watchdog expired with %0d words still owed", due_words.size());
    $display("[ascii_frame_glyph_rasterizer_top] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    in_if.valid       <= 1'b0;
    in_if.stream_byte <= '0;
    cfg_we            <= 1'b0;
    cfg_idx           <= REG_ROWS;
    cfg_data          <= '0;

    // predictor starts from the reset state and register defaults
    hdr_mode         = 1'b1;
    acc_count        = 0;
    text_row         = '0;
    text_col         = '0;
    cfg_rows         = 5'd13;
    cfg_skip         = 6'd3;
    cfg_margin       = 8'd38;
    bytes_sent       = 0;
    mismatches       = 0;
    plots_seen       = 0;
    starts_seen      = 0;
    dones_seen       = 0;
    sender_idles     = 1'b1;
    sink_idles       = 1'b1;
    sink_hold_cycles = 0;
    long_line_done   = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_header_parsing();
    test_glyph_cells();
    test_zero_rows();
    test_row_limit_lowered();
    test_bottom_clip();
    test_backpressure();
    test_random_stream();

    settle_after_results();
    mismatches += due_words.size();

    $display("Sent %0d stream bytes; checked %0d pixel plots, %0d frame starts, %0d frame ends",
             bytes_sent, plots_seen, starts_seen, dones_seen);
    $display("Settings swept to their extremes, long output hold-off included; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("[ascii_frame_glyph_rasterizer_top] OK");
    end else begin
      $display("[ascii_frame_glyph_rasterizer_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
